@@ design/vbgc_pkg.sv @@
// Shared types, widths, register codes and arithmetic helpers for the voltage bar gauge.
// No dependencies; every other design file imports this package.
package vbgc_pkg;

  // Field and datapath widths
  localparam int VOLT_W    = 12;   // millivolt sample and scale registers
  localparam int LEVEL_W   = 9;    // gauge level 0..256
  localparam int QUO_W     = 8;    // quotient bits of the level division
  localparam int IDX_W     = 2;    // led_index field
  localparam int CNT_W     = 3;    // LED counter, covers up to eight LEDs
  localparam int CH_W      = 8;    // one colour channel
  localparam int SUM_W     = 12;   // level times LED count
  localparam int PROD_W    = 17;   // colour weight times brightness
  localparam int CFG_IDX_W = 1;

  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES          = QUO_W / DIV_STEPS_PER_STAGE;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(256);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MAX = CFG_IDX_W'(1);

  localparam logic [VOLT_W-1:0] SCALE_MIN_RST = VOLT_W'(300);
  localparam logic [VOLT_W-1:0] SCALE_MAX_RST = VOLT_W'(900);

  // One stage of the level divider
  typedef struct packed {
    logic              full;
    logic              zero;
    logic [VOLT_W-1:0] rem;
    logic [VOLT_W-1:0] dvs;
    logic [QUO_W-1:0]  quo;
  } div_stage_t;

  // Level handed from the divider to the colour stage
  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] level;
  } level_beat_t;

  // Restoring division: a few quotient bits per pipeline stage
  function automatic div_stage_t div_step(input div_stage_t st);
    div_stage_t        res;
    logic [VOLT_W:0]   t;
    res = st;
    for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
      t = {res.rem, 1'b0};
      if (t >= {1'b0, res.dvs}) begin
        res.rem = VOLT_W'(t - {1'b0, res.dvs});
        res.quo = {res.quo[QUO_W-2:0], 1'b1};
      end else begin
        res.rem = t[VOLT_W-1:0];
        res.quo = {res.quo[QUO_W-2:0], 1'b0};
      end
    end
    return res;
  endfunction

  // floor(p * 255 / 65536)
  function automatic logic [CH_W-1:0] chan_scale(input logic [PROD_W-1:0] p);
    logic [PROD_W+7:0] w;
    w = {p, 8'h00} - {8'h00, p};
    return w[PROD_W+6:PROD_W-1];
  endfunction

endpackage

@@ design/vbgc_if.sv @@
// Valid/ready channel interfaces for the gauge sample input and the LED colour output.
// Depends on vbgc_pkg for field widths.
interface vbgc_in_if import vbgc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] voltage_mv;

  modport source (output valid, output voltage_mv, input ready);
  modport sink (input valid, input voltage_mv, output ready);
endinterface

interface vbgc_out_if import vbgc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] led_index;
  logic [CH_W-1:0]  red_level;
  logic [CH_W-1:0]  green_level;
  logic [CH_W-1:0]  blue_level;
  logic             last_led;

  modport source (output valid, output led_index, output red_level, output green_level,
                  output blue_level, output last_led, input ready);
  modport sink (input valid, input led_index, input red_level, input green_level,
                input blue_level, input last_led, output ready);
endinterface

@@ design/vbgc_level.sv @@
// Gauge level pipeline: range check, then a staged restoring divider giving 0..256.
// Depends on vbgc_pkg (div_stage_t, div_step, level_beat_t).
module vbgc_level import vbgc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [VOLT_W-1:0] in_volt,
  input  logic [VOLT_W-1:0] scale_min,
  input  logic [VOLT_W-1:0] scale_max,
  input  logic              advance,
  output level_beat_t       lvl_o
);

  logic [DIV_STAGES:0] valid_r;
  div_stage_t          st_r   [0:DIV_STAGES];
  div_stage_t          st_nxt [0:DIV_STAGES];

  // Classify the sample and set up the division (v - min) / (max - min),
  // then advance the divider by a few bits per stage
  always_comb begin
    st_nxt[0].full = (in_volt >= scale_max);
    st_nxt[0].zero = (in_volt < scale_max) &&
                     ((scale_max <= scale_min) || (in_volt <= scale_min));
    st_nxt[0].rem  = in_volt - scale_min;
    st_nxt[0].dvs  = scale_max - scale_min;
    st_nxt[0].quo  = '0;
    for (int k = 0; k < DIV_STAGES; k++) begin
      st_nxt[k+1] = div_step(st_r[k]);
    end
  end

  // Valid bits travel with the data; hold everything on a stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (advance) begin
      valid_r <= {valid_r[DIV_STAGES-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // Pick the level from the flags or the quotient
  always_comb begin
    lvl_o.valid = valid_r[DIV_STAGES];
    if (st_r[DIV_STAGES].full) begin
      lvl_o.level = FULL_LEVEL;
    end else if (st_r[DIV_STAGES].zero) begin
      lvl_o.level = '0;
    end else begin
      lvl_o.level = {1'b0, st_r[DIV_STAGES].quo};
    end
  end

endmodule

@@ design/vbgc_colour.sv @@
// LED serialiser and colour pipeline: one colour beat per LED, brightness, hue, scaling.
// Depends on vbgc_pkg and the vbgc_out_if interface.
module vbgc_colour import vbgc_pkg::*; #(
  parameter int LED_COUNT = 3
) (
  input  logic           clk,
  input  logic           rst_n,
  input  level_beat_t    lvl_i,
  output logic           take,
  vbgc_out_if.source     out_ch
);

  logic               busy_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [LEVEL_W-1:0] n_r;
  logic               adv;
  logic               issue;
  logic               cnt_last;

  // First colour stage
  logic               c1_valid_r;
  logic [LEVEL_W-1:0] c1_b_r, c1_xm_r, c1_xc_r;
  logic               c1_upper_r, c1_last_r;
  logic [IDX_W-1:0]   c1_idx_r;
  logic [LEVEL_W-1:0] b_nxt, xm_nxt, xc_nxt;
  logic               upper_nxt;
  logic [SUM_W-1:0]   s, base, diff;
  logic [LEVEL_W:0]   m2;

  // Second colour stage
  logic               c2_valid_r;
  logic [PROD_W-1:0]  c2_pm_r, c2_pc_r;
  logic               c2_upper_r, c2_last_r;
  logic [IDX_W-1:0]   c2_idx_r;

  // Output register
  logic               out_valid_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [CH_W-1:0]    out_red_r, out_green_r, out_blue_r;
  logic               out_last_r;
  logic [CH_W-1:0]    ch_m, ch_c;

  assign adv      = !out_valid_r || out_ch.ready;
  assign issue    = busy_r && adv;
  assign cnt_last = (cnt_r == CNT_W'(LED_COUNT - 1));
  assign take     = !busy_r || (issue && cnt_last);

  // Serialiser: hold one level and step through the LEDs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (take) begin
      busy_r <= lvl_i.valid;
      cnt_r  <= '0;
    end else if (issue) begin
      cnt_r  <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take && lvl_i.valid) begin
      n_r <= lvl_i.level;
    end
  end

  // Brightness of this LED and the hue weights
  always_comb begin
    s     = SUM_W'(n_r * LED_COUNT);
    base  = SUM_W'({cnt_r, 8'h00});
    diff  = s - base;
    if (s <= base) begin
      b_nxt = '0;
    end else if (diff > SUM_W'(FULL_LEVEL)) begin
      b_nxt = FULL_LEVEL;
    end else begin
      b_nxt = diff[LEVEL_W-1:0];
    end
    upper_nxt = n_r[LEVEL_W-1] | n_r[LEVEL_W-2];
    m2        = {n_r, 1'b0};
    if (upper_nxt) begin
      m2 = m2 - (LEVEL_W+1)'(FULL_LEVEL);
    end
    xm_nxt = m2[LEVEL_W-1:0];
    xc_nxt = FULL_LEVEL - xm_nxt;
  end

  // Advance the colour pipeline together with the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_valid_r  <= 1'b0;
      c2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      c1_valid_r  <= busy_r;
      c2_valid_r  <= c1_valid_r;
      out_valid_r <= c2_valid_r;
    end
  end

  assign ch_m = chan_scale(c2_pm_r);
  assign ch_c = chan_scale(c2_pc_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_b_r      <= b_nxt;
      c1_xm_r     <= xm_nxt;
      c1_xc_r     <= xc_nxt;
      c1_upper_r  <= upper_nxt;
      c1_idx_r    <= cnt_r[IDX_W-1:0];
      c1_last_r   <= cnt_last;

      c2_pm_r     <= PROD_W'(c1_xm_r) * PROD_W'(c1_b_r);
      c2_pc_r     <= PROD_W'(c1_xc_r) * PROD_W'(c1_b_r);
      c2_upper_r  <= c1_upper_r;
      c2_idx_r    <= c1_idx_r;
      c2_last_r   <= c1_last_r;

      out_idx_r   <= c2_idx_r;
      out_last_r  <= c2_last_r;
      out_red_r   <= c2_upper_r ? ch_m : '0;
      out_green_r <= c2_upper_r ? ch_c : ch_m;
      out_blue_r  <= c2_upper_r ? '0 : ch_c;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.led_index   = out_idx_r;
  assign out_ch.red_level   = out_red_r;
  assign out_ch.green_level = out_green_r;
  assign out_ch.blue_level  = out_blue_r;
  assign out_ch.last_led    = out_last_r;

endmodule

@@ design/voltage_bar_gauge_colors.sv @@
// Voltage bar gauge colours, top level: scale registers, level pipeline, colour pipeline.
// Depends on vbgc_pkg, vbgc_if, vbgc_level and vbgc_colour.
//
// Each accepted voltage sample produces LED_COUNT colour beats, LED 0 first, the final one
// flagged with last_led. The colour side issues one beat per cycle while the output is not
// stalled, so the sample rate is set by the LED serialiser, which holds a level until all its
// LEDs are issued. A sample crosses a five-stage level pipeline (range check and a restoring
// divider resolving two quotient bits per stage), the serialiser and three colour stages. An
// output stall holds the output register and back-pressures the stages behind it without loss.
// Scale registers reset to 300 mV and 900 mV; write them only while the block is idle. No
// clearing pass after reset.
module voltage_bar_gauge_colors import vbgc_pkg::*; #(
  parameter int LED_COUNT = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  vbgc_in_if.sink              in_ch,
  vbgc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VOLT_W-1:0]    cfg_wdata
);

  logic [VOLT_W-1:0] scale_min_r;
  logic [VOLT_W-1:0] scale_max_r;
  level_beat_t       lvl;
  logic              col_take;
  logic              lvl_adv;

  // Scale registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_min_r <= SCALE_MIN_RST;
      scale_max_r <= SCALE_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE_MIN: scale_min_r <= cfg_wdata;
        REG_SCALE_MAX: scale_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold the level pipeline only while its result waits for the serialiser
  assign lvl_adv     = !lvl.valid || col_take;
  assign in_ch.ready = lvl_adv;

  vbgc_level u_level (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_volt   (in_ch.voltage_mv),
    .scale_min (scale_min_r),
    .scale_max (scale_max_r),
    .advance   (lvl_adv),
    .lvl_o     (lvl)
  );

  vbgc_colour #(
    .LED_COUNT (LED_COUNT)
  ) u_colour (
    .clk    (clk),
    .rst_n  (rst_n),
    .lvl_i  (lvl),
    .take   (col_take),
    .out_ch (out_ch)
  );

  // Red and blue never light together on one beat
  a_no_red_blue: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.red_level == '0 || out_ch.blue_level == '0))
    else $error("red and blue both lit on one beat");

  // The flagged beat belongs to the final LED
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last_led) |-> (out_ch.led_index == IDX_W'(LED_COUNT - 1)))
    else $error("last_led on wrong LED index");

  // Input stalls only behind a level waiting for the serialiser
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (lvl.valid && !col_take))
    else $error("input stalled without a waiting level");

  // A held level is not dropped across a stall
  a_level_held: assert property (@(posedge clk) disable iff (!rst_n)
    (lvl.valid && !col_take) |=> (lvl.valid && $stable(lvl.level)))
    else $error("waiting level lost or changed");

endmodule

@@ test/testbench.sv @@
// Self-checking bench for voltage_bar_gauge_colors: sends voltage samples, predicts the
// per-LED colours and compares every output beat. Depends on vbgc_pkg and vbgc_if.
`timescale 1ns / 1ps

module testbench import vbgc_pkg::*; ();

  localparam int LEDS       = 3;
  localparam int IDLE_LIMIT = 2000;   // cycles with no beat before the run is abandoned
  localparam int DRAIN_WAIT = 20;     // beyond the pipeline latency, to catch stray beats

  typedef struct packed {
    logic [IDX_W-1:0] led_index;
    logic [CH_W-1:0]  red_level;
    logic [CH_W-1:0]  green_level;
    logic [CH_W-1:0]  blue_level;
    logic             last_led;
  } led_colour_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VOLT_W-1:0]    cfg_wdata;

  vbgc_in_if  in_ch ();
  vbgc_out_if out_ch ();

  voltage_bar_gauge_colors #(.LED_COUNT(LEDS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Bench copy of the scale registers and the colours still owed by the block
  logic [VOLT_W-1:0] scale_lo;
  logic [VOLT_W-1:0] scale_hi;
  led_colour_t       pending_colours[$];
  led_colour_t       oldest_colour;

  bit no_stalls;
  int failures;
  int samples_sent;
  int colours_seen;
  int settings_used;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Fill level 0..256 for one sample under the current scale
  function automatic int unsigned fill_level(input logic [VOLT_W-1:0] mv);
    int unsigned v, lo, hi, n;
    v  = mv;
    lo = scale_lo;
    hi = scale_hi;
    if (hi <= lo) return (v >= hi) ? 256 : 0;
    if (v <= lo) return 0;
    n = ((v - lo) * 256) / (hi - lo);
    return (n > 256) ? 256 : n;
  endfunction

  // floor(weight * 255 * brightness / 65536)
  function automatic logic [CH_W-1:0] shade(input int unsigned weight, input int unsigned bright);
    return CH_W'((weight * 255 * bright) >> 16);
  endfunction

  // Queue the colours of every LED for one accepted sample
  task automatic queue_colours(input logic [VOLT_W-1:0] mv);
    int unsigned n, s, b, m;
    led_colour_t c;
    n = fill_level(mv);
    s = n * LEDS;
    for (int i = 0; i < LEDS; i++) begin
      c = '0;
      c.led_index = IDX_W'(i);
      c.last_led  = (i == LEDS - 1);
      if (s > 256 * i) begin
        b = s - 256 * i;
        if (b > 256) b = 256;
        if (n < 128) begin
          m = 2 * n;
          c.blue_level  = shade(256 - m, b);
          c.green_level = shade(m, b);
        end else begin
          m = 2 * n - 256;
          c.green_level = shade(256 - m, b);
          c.red_level   = shade(m, b);
        end
      end
      pending_colours.push_back(c);
    end
  endtask

  // Send one sample; called and returning at a falling edge, valid left high
  task automatic send_sample(input logic [VOLT_W-1:0] mv);
    if (!no_stalls && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.voltage_mv <= mv;
    do @(posedge clk); while (!in_ch.ready);
    queue_colours(mv);
    samples_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed colour has come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write both scale registers while the block is idle
  task automatic set_scale(input logic [VOLT_W-1:0] lo, input logic [VOLT_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCALE_MIN;
    cfg_wdata <= lo;
    @(negedge clk);
    scale_lo = lo;
    cfg_index <= REG_SCALE_MAX;
    cfg_wdata <= hi;
    @(negedge clk);
    scale_hi = hi;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Reset scale: both ends, the LED hand-over points and the hue turn at mid level
  task automatic test_default_scale();
    logic [VOLT_W-1:0] points[$];
    points = '{0, 299, 300, 301, 500, 502, 598, 600, 700, 701, 899, 900, 901, 4095};
    foreach (points[k]) send_sample(points[k]);
    wait_idle();
  endtask

  // Full-range scale with alternating bit patterns
  task automatic test_wide_scale();
    set_scale(12'd0, 12'd4095);
    send_sample(12'h555);
    send_sample(12'hAAA);
    wait_idle();
  endtask

  // Empty scale: a step at the single point
  task automatic test_empty_scale();
    set_scale(12'd1000, 12'd1000);
    send_sample(12'd999);
    send_sample(12'd1000);
    wait_idle();
    set_scale(12'd4095, 12'd4095);
    send_sample(12'd4094);
    send_sample(12'd4095);
    wait_idle();
  endtask

  // Inverted and one-millivolt scales
  task automatic test_odd_scales();
    set_scale(12'd4095, 12'd0);
    send_sample(12'd0);
    wait_idle();
    set_scale(12'd0, 12'd1);
    send_sample(12'd1);
    wait_idle();
  endtask

  // Pick a sample mostly around the scale, sometimes anywhere
  function automatic logic [VOLT_W-1:0] random_sample();
    int unsigned a, c, span, bottom, top;
    a = (scale_lo < scale_hi) ? scale_lo : scale_hi;
    c = (scale_lo < scale_hi) ? scale_hi : scale_lo;
    span   = c - a + 16;
    bottom = (a > span / 8) ? a - span / 8 : 0;
    top    = (c + span / 8 > 4095) ? 4095 : c + span / 8;
    if ($urandom_range(9) < 7) return VOLT_W'($urandom_range(bottom, top));
    return VOLT_W'($urandom_range(0, 4095));
  endfunction

  // Random scales and samples; one phase runs without any idling
  task automatic test_random_samples();
    int unsigned lo, hi;
    for (int phase = 0; phase < 5; phase++) begin
      lo = $urandom_range(0, 3000);
      if (phase == 4) hi = $urandom_range(0, lo);
      else hi = lo + $urandom_range(1, 4095 - lo);
      no_stalls = (phase == 2);
      set_scale(VOLT_W'(lo), VOLT_W'(hi));
      repeat (16) send_sample(random_sample());
      wait_idle();
    end
    no_stalls = 1'b0;
  endtask

  // Receiver stalls about a quarter of the time
  always @(negedge clk) begin
    out_ch.ready <= no_stalls || ($urandom_range(99) >= 25);
  end

  // Compare each colour beat with the oldest owed colour
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      colours_seen++;
      if (pending_colours.size() == 0) begin
        $error("unexpected colour beat for led_index %0d", out_ch.led_index);
        failures++;
      end else begin
        oldest_colour = pending_colours.pop_front();
        if (out_ch.led_index !== oldest_colour.led_index) begin
          $error("led_index: expected %0d, got %0d", oldest_colour.led_index, out_ch.led_index);
          failures++;
        end
        if (out_ch.red_level !== oldest_colour.red_level) begin
          $error("red_level: expected %0d, got %0d", oldest_colour.red_level, out_ch.red_level);
          failures++;
        end
        if (out_ch.green_level !== oldest_colour.green_level) begin
          $error("green_level: expected %0d, got %0d", oldest_colour.green_level,
                 out_ch.green_level);
          failures++;
        end
        if (out_ch.blue_level !== oldest_colour.blue_level) begin
          $error("blue_level: expected %0d, got %0d", oldest_colour.blue_level,
                 out_ch.blue_level);
          failures++;
        end
        if (out_ch.last_led !== oldest_colour.last_led) begin
          $error("last_led: expected %0d, got %0d", oldest_colour.last_led, out_ch.last_led);
          failures++;
        end
      end
    end
  end

  // Abandon the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.voltage_mv = '0;
    out_ch.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_SCALE_MIN;
    cfg_wdata        = '0;
    scale_lo         = SCALE_MIN_RST;
    scale_hi         = SCALE_MAX_RST;
    no_stalls        = 1'b0;
    failures         = 0;
    samples_sent     = 0;
    colours_seen     = 0;
    settings_used    = 1;
    idle_cycles      = 0;

    // Hold reset, release at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_scale();
    test_wide_scale();
    test_empty_scale();
    test_odd_scales();
    test_random_samples();

    // Let any stray beat show itself
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_colours.size() != 0) begin
      $error("%0d colours never arrived", pending_colours.size());
      failures++;
    end

    $display("Sent %0d samples over %0d scale settings, checked %0d colour beats",
             samples_sent, settings_used, colours_seen);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/vbgc_pkg.sv
design/vbgc_if.sv
design/vbgc_level.sv
design/vbgc_colour.sv
design/voltage_bar_gauge_colors.sv
test/testbench.sv
